// ===== sv/mrlc_pkg.sv =====
// Shared constants and types for the monochrome raster line/circle engine.
package mrlc_pkg;

    // Frame store size in bytes, default
    localparam int unsigned STORE_BYTES_DEF = 65536;

    // Width of internal byte addresses (covers y*stride + x/8 worst case)
    localparam int unsigned ADDR_W = 24;

    // Register reset values
    localparam logic [11:0] XRES_RST   = 12'd640;
    localparam logic [11:0] YRES_RST   = 12'd480;
    localparam logic [9:0]  STRIDE_RST = 10'd80;

    // Register indexes
    localparam logic [1:0] CFG_XRES   = 2'd0;
    localparam logic [1:0] CFG_YRES   = 2'd1;
    localparam logic [1:0] CFG_STRIDE = 2'd2;

    // Action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_CIRCLE = 2'd1;
    localparam logic [1:0] ACT_LINE   = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // Root width of the square root unit
    localparam int unsigned ROOT_W = 12;

    typedef logic signed [14:0] t_s15;
    typedef logic signed [15:0] t_s16;

    // Start/result handshake between sequencer and square root unit
    typedef struct packed {
        logic                start;
        logic [2*ROOT_W-1:0] rem;
    } t_sq_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sq_rsp;

endpackage

// ===== sv/mono_raster_line_circle_engine.sv =====
// Top level: command sequencer around a 1 bpp frame store.
//
//  channel | direction | signals                                   | handshake
//  --------+-----------+-------------------------------------------+----------------------
//  in      | input     | action, x_a, y_a, x_b, y_b, radius, addr  | i_in_valid/o_in_ready
//  out     | output    | read_data                                 | o_out_valid/i_out_ready
//  cfg     | input     | i_cfg_idx, i_cfg_data                     | i_cfg_we
//
// One item at a time; every pixel is a read-modify-write of the store's single
// port through address, read and write states; a line adds its step and advance
// states per point, a circle its span state per pixel. Circle rows also need a row
// multiply and a square root on top of pixels.
// Clear zeroes min(y_resolution*row_stride_bytes, STORE_BYTES) bytes; read returns one byte.
// After reset a clearing pass over all STORE_BYTES bytes runs before the first item.
// The result register frees the sequencer once the result is loaded; a stalled
// output only holds the next item at its final state.
module mono_raster_line_circle_engine #(
    parameter int unsigned STORE_BYTES = mrlc_pkg::STORE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic signed [12:0] i_x_a,
    input  logic signed [12:0] i_y_a,
    input  logic signed [12:0] i_x_b,
    input  logic signed [12:0] i_y_b,
    input  logic [11:0] i_radius,
    input  logic [15:0] i_read_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data
);

    localparam int unsigned AW = $clog2(STORE_BYTES);
    localparam int unsigned NW = mrlc_pkg::ADDR_W;
    localparam logic [NW:0] STORE_L = (NW+1)'(STORE_BYTES);

    // State codes
    localparam logic [3:0] S_WIPE   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CLR    = 4'd2;
    localparam logic [3:0] S_RD0    = 4'd3;
    localparam logic [3:0] S_RD1    = 4'd4;
    localparam logic [3:0] S_C_BOX  = 4'd5;
    localparam logic [3:0] S_C_ROW  = 4'd6;
    localparam logic [3:0] S_C_REM  = 4'd7;
    localparam logic [3:0] S_C_SQ   = 4'd8;
    localparam logic [3:0] S_C_PIX  = 4'd9;
    localparam logic [3:0] S_L_STEP = 4'd10;
    localparam logic [3:0] S_L_ADV  = 4'd11;
    localparam logic [3:0] S_P_ADDR = 4'd12;
    localparam logic [3:0] S_P_RD   = 4'd13;
    localparam logic [3:0] S_P_WR   = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    // Configuration
    logic [11:0] r_xres;
    logic [11:0] r_yres;
    logic [9:0]  r_stride;

    // Control
    logic [3:0]  r_state;
    logic [3:0]  r_ret;
    logic [NW-1:0] r_cnt;
    logic [NW:0]   r_lim;
    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic [7:0]  r_result;

    // Pixel write
    logic [11:0]   r_px;
    logic [11:0]   r_py;
    logic [NW-1:0] r_addr;
    logic [7:0]    r_mask;

    // Circle
    mrlc_pkg::t_s15 r_cx, r_cy, r_minx, r_maxx, r_maxy, r_b, r_a, r_e;
    logic [11:0]    r_r;
    logic [23:0]    r_r2;
    logic [26:0]    r_dy2;

    // Line
    logic signed [12:0] r_x0, r_y0, r_x1, r_y1;
    mrlc_pkg::t_s16     r_dx, r_dy, r_err;
    logic               r_sx, r_sy;

    // Memory port
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    mrlc_pkg::t_sq_req sq_req;
    mrlc_pkg::t_sq_rsp sq_rsp;

    // Combinational helpers
    mrlc_pkg::t_s15 c_minx, c_maxx, c_miny, c_maxy, c_xr, c_yr, c_dy, c_s, c_e;
    logic signed [29:0] c_dy_sq;
    logic signed [27:0] c_rem;
    logic signed [16:0] c_e2;
    mrlc_pkg::t_s16     c_err;
    logic signed [12:0] c_x0n, c_y0n;
    logic               c_onscr;
    logic [21:0]        c_clr_n;
    logic               out_free;
    logic               in_acc;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Circle bounding box
    assign c_xr   = mrlc_pkg::t_s15'({3'b000, r_xres});
    assign c_yr   = mrlc_pkg::t_s15'({3'b000, r_yres});
    assign c_minx = r_cx - mrlc_pkg::t_s15'({3'b000, r_r});
    assign c_maxx = r_cx + mrlc_pkg::t_s15'({3'b000, r_r});
    assign c_miny = r_cy - mrlc_pkg::t_s15'({3'b000, r_r});
    assign c_maxy = r_cy + mrlc_pkg::t_s15'({3'b000, r_r});

    // Row distance and remainder
    assign c_dy    = r_b - r_cy;
    assign c_dy_sq = c_dy * c_dy;
    assign c_rem   = $signed({4'b0000, r_r2}) - $signed({1'b0, r_dy2});

    // Span ends from the root
    assign c_s = r_cx - mrlc_pkg::t_s15'({3'b000, sq_rsp.root});
    assign c_e = r_cx + mrlc_pkg::t_s15'({3'b000, sq_rsp.root});

    // Bresenham step
    assign c_e2    = {r_err, 1'b0};
    assign c_onscr = !r_x0[12] && (r_x0[11:0] < r_xres) && !r_y0[12] && (r_y0[11:0] < r_yres);
    always_comb begin
        c_err = r_err;
        c_x0n = r_x0;
        c_y0n = r_y0;
        if (c_e2 > 17'(r_dy)) begin
            c_err = c_err + r_dy;
            c_x0n = r_sx ? r_x0 + 13'sd1 : r_x0 - 13'sd1;
        end
        if (c_e2 < 17'(r_dx)) begin
            c_err = c_err + r_dx;
            c_y0n = r_sy ? r_y0 + 13'sd1 : r_y0 - 13'sd1;
        end
    end

    assign c_clr_n = r_yres * r_stride;

    // Memory port drive
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_addr[AW-1:0];
        ram_wdata = ram_rdata | r_mask;
        case (r_state)
            S_WIPE, S_CLR: begin
                ram_we    = ({1'b0, r_cnt} < r_lim);
                ram_addr  = r_cnt[AW-1:0];
                ram_wdata = '0;
            end
            S_RD0, S_P_RD: begin
                ram_re = ({1'b0, r_addr} < STORE_L);
            end
            S_P_WR: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign sq_req.start = (r_state == S_C_REM) && !c_rem[27];
    assign sq_req.rem   = c_rem[23:0];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xres   <= mrlc_pkg::XRES_RST;
            r_yres   <= mrlc_pkg::YRES_RST;
            r_stride <= mrlc_pkg::STRIDE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mrlc_pkg::CFG_XRES:   r_xres   <= i_cfg_data;
                mrlc_pkg::CFG_YRES:   r_yres   <= i_cfg_data;
                mrlc_pkg::CFG_STRIDE: r_stride <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // Result register: load on completion, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
            r_out_data  <= r_result;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_ret       <= S_IDLE;
            r_cnt       <= '0;
            r_lim       <= STORE_L;
        end else begin
            case (r_state)
                S_WIPE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if ({1'b0, r_cnt} + 1'b1 >= r_lim) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_result <= '0;
                        r_cx     <= mrlc_pkg::t_s15'(i_x_a);
                        r_cy     <= mrlc_pkg::t_s15'(i_y_a);
                        r_r      <= i_radius;
                        r_x0     <= i_x_a;
                        r_y0     <= i_y_a;
                        r_x1     <= i_x_b;
                        r_y1     <= i_y_b;
                        r_addr   <= NW'(i_read_address);
                        case (i_action)
                            mrlc_pkg::ACT_CLEAR: begin
                                r_cnt   <= '0;
                                r_lim   <= ((NW+1)'(c_clr_n) > STORE_L) ? STORE_L
                                                                        : (NW+1)'(c_clr_n);
                                r_state <= S_CLR;
                            end
                            mrlc_pkg::ACT_CIRCLE: begin
                                r_state <= S_C_BOX;
                            end
                            mrlc_pkg::ACT_LINE: begin
                                r_dx    <= (i_x_b > i_x_a) ? 16'(i_x_b) - 16'(i_x_a)
                                                           : 16'(i_x_a) - 16'(i_x_b);
                                r_dy    <= (i_y_b > i_y_a) ? 16'(i_y_a) - 16'(i_y_b)
                                                           : 16'(i_y_b) - 16'(i_y_a);
                                r_err   <= ((i_x_b > i_x_a) ? 16'(i_x_b) - 16'(i_x_a)
                                                            : 16'(i_x_a) - 16'(i_x_b))
                                         + ((i_y_b > i_y_a) ? 16'(i_y_a) - 16'(i_y_b)
                                                            : 16'(i_y_b) - 16'(i_y_a));
                                r_sx    <= i_x_a < i_x_b;
                                r_sy    <= i_y_a < i_y_b;
                                r_state <= S_L_STEP;
                            end
                            default: begin
                                r_state <= S_RD0;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    if ({1'b0, r_cnt} < r_lim) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    if ({1'b0, r_addr} < STORE_L) begin
                        r_result <= ram_rdata;
                    end
                    r_state <= S_DONE;
                end
                // Bounding box clip; skip when it misses the screen
                S_C_BOX: begin
                    if (c_minx >= c_xr || c_miny >= c_yr || c_maxx < 0 || c_maxy < 0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_minx  <= (c_minx < 0) ? '0 : c_minx;
                        r_b     <= (c_miny < 0) ? '0 : c_miny;
                        r_maxx  <= (c_maxx >= c_xr) ? c_xr - 15'sd1 : c_maxx;
                        r_maxy  <= (c_maxy >= c_yr) ? c_yr - 15'sd1 : c_maxy;
                        r_r2    <= r_r * r_r;
                        r_state <= S_C_ROW;
                    end
                end
                S_C_ROW: begin
                    if (r_b > r_maxy) begin
                        r_state <= S_DONE;
                    end else begin
                        r_dy2   <= c_dy_sq[26:0];
                        r_state <= S_C_REM;
                    end
                end
                S_C_REM: begin
                    if (c_rem[27]) begin
                        r_b     <= r_b + 15'sd1;
                        r_state <= S_C_ROW;
                    end else begin
                        r_state <= S_C_SQ;
                    end
                end
                S_C_SQ: begin
                    if (sq_rsp.done) begin
                        r_a     <= (c_s < r_minx) ? r_minx : c_s;
                        r_e     <= (c_e > r_maxx) ? r_maxx : c_e;
                        r_state <= S_C_PIX;
                    end
                end
                S_C_PIX: begin
                    if (r_a > r_e) begin
                        r_b     <= r_b + 15'sd1;
                        r_state <= S_C_ROW;
                    end else begin
                        r_px    <= r_a[11:0];
                        r_py    <= r_b[11:0];
                        r_a     <= r_a + 15'sd1;
                        r_ret   <= S_C_PIX;
                        r_state <= S_P_ADDR;
                    end
                end
                S_L_STEP: begin
                    if (c_onscr) begin
                        r_px    <= r_x0[11:0];
                        r_py    <= r_y0[11:0];
                        r_ret   <= S_L_ADV;
                        r_state <= S_P_ADDR;
                    end else begin
                        r_state <= S_L_ADV;
                    end
                end
                S_L_ADV: begin
                    if (r_x0 == r_x1 && r_y0 == r_y1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_err   <= c_err;
                        r_x0    <= c_x0n;
                        r_y0    <= c_y0n;
                        r_state <= S_L_STEP;
                    end
                end
                // Pixel read-modify-write
                S_P_ADDR: begin
                    r_addr  <= NW'(r_px[11:3]) + NW'(r_py) * NW'(r_stride);
                    r_mask  <= 8'd1 << r_px[2:0];
                    r_state <= S_P_RD;
                end
                S_P_RD: begin
                    r_state <= ({1'b0, r_addr} < STORE_L) ? S_P_WR : r_ret;
                end
                S_P_WR: begin
                    r_state <= r_ret;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    mrlc_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    mrlc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    // Store writes only come from clearing or a pixel update
    a_we_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_WIPE || r_state == S_CLR || r_state == S_P_WR))
        else $error("store write outside clear or pixel update");

    // Pixel write always follows its read
    a_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P_WR) |-> ($past(r_state) == S_P_RD))
        else $error("pixel write without preceding read");

    // Root result moves the circle to its span
    a_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_C_SQ && sq_rsp.done) |=> (r_state == S_C_PIX))
        else $error("root result lost");

    // Square root only started by the circle sequencer
    a_sq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_req.start |=> (r_state == S_C_SQ))
        else $error("square root started outside circle row");

endmodule

// ===== sv/mrlc_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module mrlc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mrlc_isqrt.sv =====
// Bit-serial integer square root: one root bit per cycle.
module mrlc_isqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mrlc_pkg::t_sq_req i_req,
    output mrlc_pkg::t_sq_rsp o_rsp
);

    localparam int unsigned RW = mrlc_pkg::ROOT_W;
    localparam int unsigned BW = $clog2(RW);

    logic            r_busy;
    logic            r_done;
    logic [BW-1:0]   r_bit;
    logic [RW-1:0]   r_root;
    logic [2*RW-1:0] r_rem;

    logic [RW-1:0]   trial;
    logic [2*RW-1:0] trial_sq;

    // Try setting the current bit
    assign trial    = r_root | (RW'(1) << r_bit);
    assign trial_sq = trial * trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_bit  <= BW'(RW - 1);
                r_root <= '0;
                r_rem  <= i_req.rem;
            end else if (r_busy) begin
                if (trial_sq <= r_rem) begin
                    r_root <= trial;
                end
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

// ===== bench/mono_raster_line_circle_engine_tb.sv =====
// Self-checking bench for the raster engine: shadow frame store, random commands, handshakes.
module mono_raster_line_circle_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_BYTES = 65536;

    // Input item as offered to the engine
    typedef struct {
        logic [1:0]         action;
        logic signed [12:0] x_a;
        logic signed [12:0] y_a;
        logic signed [12:0] x_b;
        logic signed [12:0] y_b;
        logic [11:0]        radius;
        logic [15:0]        read_address;
    } t_cmd;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [11:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_action;
    logic signed [12:0] i_x_a;
    logic signed [12:0] i_y_a;
    logic signed [12:0] i_x_b;
    logic signed [12:0] i_y_b;
    logic [11:0]        i_radius;
    logic [15:0]        i_read_address;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [7:0]         o_read_data;

    mono_raster_line_circle_engine uut (.*);

    // Shadow state
    logic [7:0]  shadow_store [STORE_BYTES];
    int          xres_m, yres_m, stride_m;

    t_cmd        pending_cmds[$];
    logic [7:0]  expected_bytes[$];
    int          errors;
    int          send_idle_pct, recv_idle_pct;
    int          hold_off_cycles;
    int          n_accepted, n_checked;
    logic        o_in_ready_seen;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor helpers
    function automatic void set_pixel(int x, int y);
        longint addr;
        addr = longint'(x >>> 3) + longint'(y) * stride_m;
        if (addr < STORE_BYTES)
            shadow_store[addr] |= 8'(1 << (x & 7));
    endfunction

    function automatic void fill_disc(int cx, int cy, int r);
        int minx, maxx, miny, maxy, b, a, s, e;
        longint r2, dy, rem, d;
        minx = cx - r; maxx = cx + r; miny = cy - r; maxy = cy + r;
        r2 = longint'(r) * r;
        if (minx >= xres_m || miny >= yres_m || maxx < 0 || maxy < 0)
            return;
        if (minx < 0) minx = 0;
        if (miny < 0) miny = 0;
        if (maxx >= xres_m) maxx = xres_m - 1;
        if (maxy >= yres_m) maxy = yres_m - 1;
        for (b = miny; b <= maxy; b++) begin
            dy = b - cy;
            rem = r2 - dy * dy;
            if (rem >= 0) begin
                d = 0;
                while ((d + 1) * (d + 1) <= rem) d++;
                s = cx - int'(d);
                e = cx + int'(d);
                if (s < minx) s = minx;
                if (e > maxx) e = maxx;
                for (a = s; a <= e; a++) set_pixel(a, b);
            end
        end
    endfunction

    function automatic void trace_line(int x0, int y0, int x1, int y1);
        int dx, dy, sx, sy, err, e2;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y0 - y1 : y1 - y0;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        err = dx + dy;
        forever begin
            if (x0 >= 0 && x0 < xres_m && y0 >= 0 && y0 < yres_m)
                set_pixel(x0, y0);
            if (x0 == x1 && y0 == y1) break;
            e2 = 2 * err;
            if (e2 > dy) begin err += dy; x0 += sx; end
            if (e2 < dx) begin err += dx; y0 += sy; end
        end
    endfunction

    // Apply one command to the shadow store; returns the expected byte
    function automatic logic [7:0] predict_byte(t_cmd c);
        longint n;
        predict_byte = 8'h00;
        case (c.action)
            mrlc_pkg::ACT_CLEAR: begin
                n = longint'(yres_m) * stride_m;
                if (n > STORE_BYTES) n = STORE_BYTES;
                for (longint k = 0; k < n; k++) shadow_store[k] = 8'h00;
            end
            mrlc_pkg::ACT_CIRCLE: fill_disc(c.x_a, c.y_a, int'(c.radius));
            mrlc_pkg::ACT_LINE:   trace_line(c.x_a, c.y_a, c.x_b, c.y_b);
            default:              predict_byte = shadow_store[c.read_address];
        endcase
    endfunction

    // Driver: offers queued items, idles at random between them
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready_seen) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid     <= 1'b1;
                i_action       <= pending_cmds[0].action;
                i_x_a          <= pending_cmds[0].x_a;
                i_y_a          <= pending_cmds[0].y_a;
                i_x_b          <= pending_cmds[0].x_b;
                i_y_b          <= pending_cmds[0].y_b;
                i_radius       <= pending_cmds[0].radius;
                i_read_address <= pending_cmds[0].read_address;
                void'(pending_cmds.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Acceptance at the rising edge; predict there
    always @(posedge i_clk) begin
        t_cmd c;
        o_in_ready_seen <= 1'b0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            o_in_ready_seen <= 1'b1;
            c.action = i_action; c.x_a = i_x_a; c.y_a = i_y_a;
            c.x_b = i_x_b; c.y_b = i_y_b; c.radius = i_radius;
            c.read_address = i_read_address;
            expected_bytes.push_back(predict_byte(c));
            n_accepted++;
        end
    end

    // Receiver ready, with random stalls and an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            i_out_ready     <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        logic [7:0] exp_byte;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected result read_data=%h", $realtime, o_read_data);
                errors++;
            end else begin
                exp_byte = expected_bytes.pop_front();
                n_checked++;
                if (o_read_data !== exp_byte) begin
                    $display("%0t: read_data mismatch expected %h actual %h",
                             $realtime, exp_byte, o_read_data);
                    errors++;
                end
            end
        end
    end

    function automatic t_cmd make_cmd(logic [1:0] act, int xa, int ya, int xb, int yb,
                                      int r, int addr);
        t_cmd c;
        c.action = act; c.x_a = 13'(xa); c.y_a = 13'(ya); c.x_b = 13'(xb);
        c.y_b = 13'(yb); c.radius = 12'(r); c.read_address = 16'(addr);
        return c;
    endfunction

    // Random coordinate: mostly near the screen, sometimes anywhere
    function automatic int rand_coord(int span);
        if ($urandom_range(9) == 0)
            return int'($signed(13'($urandom)));
        return int'($urandom_range(span + 40)) - 20;
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int sel;
        sel = $urandom_range(99);
        c = make_cmd(mrlc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
        c.x_b = 13'($urandom); c.y_b = 13'($urandom);
        c.radius = 12'($urandom); c.read_address = 16'($urandom);
        if (sel < 4) begin
            c.action = mrlc_pkg::ACT_CLEAR;
        end else if (sel < 30) begin
            c.action = mrlc_pkg::ACT_CIRCLE;
            c.x_a = 13'(rand_coord(xres_m)); c.y_a = 13'(rand_coord(yres_m));
            c.radius = ($urandom_range(19) == 0) ? 12'($urandom) : 12'($urandom_range(12));
        end else if (sel < 60) begin
            c.action = mrlc_pkg::ACT_LINE;
            c.x_a = 13'(rand_coord(xres_m)); c.y_a = 13'(rand_coord(yres_m));
            c.x_b = 13'(int'(c.x_a) + int'($urandom_range(60)) - 30);
            c.y_b = 13'(int'(c.y_a) + int'($urandom_range(60)) - 30);
        end else begin
            c.action = mrlc_pkg::ACT_READ;
            // mostly bytes in the drawn area
            if ($urandom_range(4) != 0)
                c.read_address = 16'($urandom_range(yres_m * stride_m + 8));
        end
        return c;
    endfunction

    task automatic write_reg(logic [1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 12'(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            mrlc_pkg::CFG_XRES: xres_m   = value & 12'hFFF;
            mrlc_pkg::CFG_YRES: yres_m   = value & 12'hFFF;
            default:            stride_m = value & 10'h3FF;
        endcase
    endtask

    task automatic drain();
        wait (pending_cmds.size() == 0 && !i_in_valid && expected_bytes.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_phase(int count, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (count) pending_cmds.push_back(rand_cmd());
        drain();
    endtask

    initial begin
        errors = 0; n_accepted = 0; n_checked = 0; hold_off_cycles = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = mrlc_pkg::CFG_XRES; i_cfg_data = '0;
        i_in_valid = 1'b0; i_out_ready = 1'b0; o_in_ready_seen = 1'b0;
        i_action = mrlc_pkg::ACT_CLEAR; i_x_a = '0; i_y_a = '0; i_x_b = '0; i_y_b = '0;
        i_radius = '0; i_read_address = '0;
        foreach (shadow_store[k]) shadow_store[k] = 8'h00;
        xres_m = 640; yres_m = 480; stride_m = 80;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: small screen to keep draws short
        write_reg(mrlc_pkg::CFG_XRES, 64);
        write_reg(mrlc_pkg::CFG_YRES, 32);
        write_reg(mrlc_pkg::CFG_STRIDE, 8);
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_CIRCLE, 10, 10, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_CIRCLE, 30, 16, 0, 0, 5, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_CIRCLE, -3, -2, 0, 0, 6, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_CIRCLE, 4095, 4095, 0, 0, 4095, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_CIRCLE, -4096, -4096, 0, 0, 3, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_LINE, -5, -5, 70, 40, 0, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_LINE, 63, 0, 0, 31, 0, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_LINE, 12, 12, 12, 12, 0, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_LINE, 4095, -4096, 4090, -4090, 0, 0));
        for (int k = 0; k < 6; k++)
            pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_READ, 0, 0, 0, 0, 0, k * 21 + 1));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_READ, 0, 0, 0, 0, 0, 65535));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_READ, 0, 0, 0, 0, 0, 34));
        drain();

        // Long receiver hold-off while the sender keeps offering reads
        hold_off_cycles = 300;
        for (int k = 0; k < 8; k++)
            pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_READ, 0, 0, 0, 0, 0, k));
        drain();

        random_phase(45, 26, 49);

        // Zero stride and zero x resolution
        write_reg(mrlc_pkg::CFG_STRIDE, 0);
        write_reg(mrlc_pkg::CFG_XRES, 0);
        random_phase(10, 0, 0);
        write_reg(mrlc_pkg::CFG_XRES, 100);
        random_phase(15, 49, 26);

        // Maximum extents: rows beyond the store are dropped
        write_reg(mrlc_pkg::CFG_XRES, 4095);
        write_reg(mrlc_pkg::CFG_YRES, 4095);
        write_reg(mrlc_pkg::CFG_STRIDE, 512);
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_LINE, 4000, 120, 4094, 140, 0, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_CIRCLE, 4090, 127, 0, 0, 4, 0));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_READ, 0, 0, 0, 0, 0, 127 * 512 + 511));
        pending_cmds.push_back(make_cmd(mrlc_pkg::ACT_READ, 0, 0, 0, 0, 0, 126 * 512 + 511));
        drain();
        write_reg(mrlc_pkg::CFG_XRES, 1);
        write_reg(mrlc_pkg::CFG_YRES, 1);
        write_reg(mrlc_pkg::CFG_STRIDE, 1);
        random_phase(10, 0, 0);
        write_reg(mrlc_pkg::CFG_XRES, 48);
        write_reg(mrlc_pkg::CFG_YRES, 24);
        write_reg(mrlc_pkg::CFG_STRIDE, 6);
        random_phase(40, 0, 0);

        $display("Covered %0d commands, %0d results checked, across six register settings",
                 n_accepted, n_checked);
        $display("including clipped draws, zero stride, store overflow and a long output stall");
        if (errors == 0)
            $display("mono_raster_line_circle_engine verification clean");
        else
            $display("mono_raster_line_circle_engine verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #40ms;
        $display("mono_raster_line_circle_engine verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/mrlc_pkg.sv
sv/mrlc_ram.sv
sv/mrlc_isqrt.sv
sv/mono_raster_line_circle_engine.sv
bench/mono_raster_line_circle_engine_tb.sv
